[hdl/pss_pkg.sv]
package pss_pkg;

   localparam int PSS_NUM_SLOTS   = 16;
   localparam int PSS_EVENT_LIMIT = 16;
   localparam int PSS_TICK_W      = 32;
   localparam int PSS_SLOT_W      = 4;
   localparam int PSS_SCAN_W      = 7;
   localparam int PSS_ACTIVE_W    = 5;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_START = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [PSS_TICK_W-1:0] period;
      logic [PSS_TICK_W-1:0] next_due;
   } slot_type;

   // Outcome of one slot passing through the head unit.
   typedef struct packed {
      logic hit;
      logic missed;
   } head_result_type;

endpackage

[hdl/pss_cell.sv]
module pss_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  pss_pkg::slot_type slot_d,
   output pss_pkg::slot_type slot_q
);
   import pss_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   // Each cell takes its neighbor's slot whenever the ring advances.
   always_comb begin
      slot_in = shift_en ? slot_d : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_q = slot_ff;

endmodule

[hdl/pss_head.sv]
module pss_head (
   input  pss_pkg::action_type               action,
   input  logic                              load_hit,
   input  logic                              in_scan,
   input  logic [pss_pkg::PSS_TICK_W-1:0]    period_in,
   input  logic [pss_pkg::PSS_TICK_W-1:0]    now,
   input  pss_pkg::slot_type                 slot_in,
   output pss_pkg::slot_type                 slot_out,
   output pss_pkg::head_result_type          result
);
   import pss_pkg::*;

   logic [PSS_TICK_W-1:0] lag;
   logic                  due;
   logic                  late;
   logic [PSS_TICK_W-1:0] base;
   logic [PSS_TICK_W-1:0] addend;
   logic [PSS_TICK_W-1:0] sum;

   // Wrap-safe lateness: the sign bit of the difference tells early from due.
   assign lag  = now - slot_in.next_due;
   assign due  = in_scan && (slot_in.period != '0) && !lag[PSS_TICK_W-1];
   assign late = lag >= slot_in.period;

   // One adder serves every update: an on-time fire advances from the old
   // deadline, everything else arms from the current tick.
   always_comb begin
      base   = now;
      addend = slot_in.period;
      if (action == ACT_LOAD) begin
         addend = period_in;
      end else if (action == ACT_TICK && !late) begin
         base = slot_in.next_due;
      end
   end

   assign sum = base + addend;

   always_comb begin
      slot_out      = slot_in;
      result.hit    = 1'b0;
      result.missed = 1'b0;
      unique case (action)
         ACT_LOAD: begin
            if (load_hit) begin
               slot_out.period   = period_in;
               slot_out.next_due = sum;
            end
         end
         ACT_START: begin
            slot_out.next_due = sum;
         end
         ACT_TICK: begin
            if (due) begin
               slot_out.next_due = sum;
               result.hit        = 1'b1;
               result.missed     = late;
            end
         end
         default: begin
            slot_out = slot_in;
         end
      endcase
   end

endmodule

[hdl/periodic_slot_scheduler.sv]
// Periodic slot scheduler.
// Items arrive on the req_ channel (valid/stall). A tick item carries the
// current tick count and produces one rsp_ transfer per slot that is due,
// in ascending slot order, with rsp_last set on the final one; a tick with
// nothing due produces no transfer. Load and start items produce none.
// The csr_ port writes the number of slots scanned per tick; write it only
// while the block is idle.
// The slot table lives in a ring of cells that rotates one slot per cycle,
// unless paused by a receiver stall, past a single head unit. An item is
// accepted while idle, rotates all NUM_SLOTS slots past the head and then
// hands over the last pending event, and only then is a new item taken.
// An event is held back until the next due slot reaches the head or the
// rotation ends, so that its last flag is known. req_stall is high while
// an item is in progress.
// When the receiver stalls, the finished result waits in the output
// register; one more event may be held internally, after which the ring
// pauses until the output register frees up.
// Synchronous reset clears all periods and deadlines (all slots disabled),
// sets the scan count to zero and empties the output.
module periodic_slot_scheduler #(
   parameter int NUM_SLOTS = pss_pkg::PSS_NUM_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [3:0]                          req_slot_index,
   input  logic [pss_pkg::PSS_TICK_W-1:0]      req_period_ticks,
   input  logic [pss_pkg::PSS_TICK_W-1:0]      req_now_tick,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pss_pkg::PSS_SLOT_W-1:0]      rsp_event_slot,
   output logic                                rsp_missed,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [pss_pkg::PSS_ACTIVE_W-1:0]    csr_wr_data
);
   import pss_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // Control state.
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [PSS_ACTIVE_W-1:0] active_ff;

   // The item being worked on.
   action_type            act_ff;
   logic [3:0]            idx_ff;
   logic [PSS_TICK_W-1:0] period_ff;
   logic [PSS_TICK_W-1:0] now_ff;

   // One event is held back until we know whether another one follows,
   // which decides its last flag.
   logic                  pend_valid_ff, pend_valid_in;
   logic [PSS_SLOT_W-1:0] pend_slot_ff;
   logic                  pend_missed_ff;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PSS_SLOT_W-1:0] rsp_slot_ff;
   logic                  rsp_missed_ff;
   logic                  rsp_last_ff;

   logic                  req_take;
   logic                  out_free;
   logic                  shift_en;
   logic                  flush_move;
   logic                  run_move;
   logic                  out_load;
   logic                  last_step;
   logic [PSS_SCAN_W-1:0] scan_lim;
   logic [PSS_SCAN_W-1:0] cnt_ext;
   logic                  load_hit;
   logic                  in_scan;
   logic [PSS_SLOT_W-1:0] cur_slot;

   slot_type              chain_q [NUM_SLOTS];
   slot_type              head_out;
   head_result_type       head_res;

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = cnt_ff == IDX_W'(NUM_SLOTS - 1);

   // Scan count saturates at the table size and at the event slot range.
   always_comb begin
      scan_lim = PSS_SCAN_W'(active_ff);
      if (scan_lim > PSS_SCAN_W'(NUM_SLOTS)) begin
         scan_lim = PSS_SCAN_W'(NUM_SLOTS);
      end
      if (scan_lim > PSS_SCAN_W'(PSS_EVENT_LIMIT)) begin
         scan_lim = PSS_SCAN_W'(PSS_EVENT_LIMIT);
      end
   end

   // Slot number at the head of the ring equals the rotation count.
   assign cnt_ext  = PSS_SCAN_W'(cnt_ff);
   assign load_hit = cnt_ext == PSS_SCAN_W'(idx_ff);
   assign in_scan  = cnt_ext < scan_lim;
   assign cur_slot = cnt_ext[PSS_SLOT_W-1:0];

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (shift_en && last_step) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State machine outputs. The ring only pauses when a new event would
   // need the holding slot while it is full and a stalled result fills the output register.
   always_comb begin
      req_stall  = 1'b1;
      shift_en   = 1'b0;
      flush_move = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_RUN: begin
            shift_en = !(head_res.hit && pend_valid_ff && !out_free);
         end
         ST_FLUSH: begin
            flush_move = pend_valid_ff && out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign run_move = shift_en && head_res.hit && pend_valid_ff;
   assign out_load = run_move || flush_move;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_take) begin
         cnt_in = '0;
      end else if (shift_en) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (shift_en && head_res.hit) begin
         pend_valid_in = 1'b1;
      end else if (flush_move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff    <= action_type'(req_action);
         idx_ff    <= req_slot_index;
         period_ff <= req_period_ticks;
         now_ff    <= req_now_tick;
      end
      if (shift_en && head_res.hit) begin
         pend_slot_ff   <= cur_slot;
         pend_missed_ff <= head_res.missed;
      end
      if (out_load) begin
         rsp_slot_ff   <= pend_slot_ff;
         rsp_missed_ff <= pend_missed_ff;
         rsp_last_ff   <= flush_move;
      end
   end

   // Head unit: updates the slot at cell zero on its way to the ring's tail.
   pss_head u_head (
      .action    (act_ff),
      .load_hit  (load_hit),
      .in_scan   (in_scan),
      .period_in (period_ff),
      .now       (now_ff),
      .slot_in   (chain_q[0]),
      .slot_out  (head_out),
      .result    (head_res)
   );

   // Ring of slot cells; after NUM_SLOTS steps each slot is back in place.
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      slot_type cell_d;
      if (i == NUM_SLOTS - 1) begin : g_tail
         assign cell_d = head_out;
      end else begin : g_mid
         assign cell_d = chain_q[i+1];
      end
      pss_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .slot_d   (cell_d),
         .slot_q   (chain_q[i])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_slot = rsp_slot_ff;
   assign rsp_missed     = rsp_missed_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

[hdl/pss_checker.sv]
module pss_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [pss_pkg::PSS_SLOT_W-1:0]   rsp_event_slot,
   input logic                             rsp_missed,
   input logic                             rsp_last
);
   import pss_pkg::*;

   // A stalled result holds until it is taken.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_slot)
         && $stable(rsp_missed) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Every accepted item keeps the block busy for at least the next cycle.
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after a transfer");

   // Reset leaves the block idle with an empty output.
   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind periodic_slot_scheduler pss_checker u_pss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_event_slot (rsp_event_slot),
   .rsp_missed     (rsp_missed),
   .rsp_last       (rsp_last)
);
